// ===== rtl/brr_pkg.sv =====
// Shared types and constants for the barcode row rasterizer.
`timescale 1ns / 1ps
package brr_pkg;

  localparam int LINE_BYTES   = 64;
  localparam int MAX_ELEMENTS = 128;
  localparam int LINE_PIXELS  = LINE_BYTES * 8;
  localparam int ELEM_AW      = $clog2(MAX_ELEMENTS);
  localparam int LINE_AW      = $clog2(LINE_BYTES);
  localparam int RUN_W        = 13;

  localparam logic [7:0] WHITE_BYTE = 8'hFF;

  localparam logic [1:0] REG_PIX_MULT   = 2'd0;
  localparam logic [1:0] REG_X_UNDERCUT = 2'd1;
  localparam logic [1:0] REG_BMP_MODE   = 2'd2;

  localparam logic OP_HEADER  = 1'b0;
  localparam logic OP_ELEMENT = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [RUN_W-1:0] width;
    logic             colour;
    logic             last;
  } run_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] line;
    logic [7:0] ucut;
    logic       last;
  } res_t;

endpackage

// ===== rtl/brr_runs.sv =====
// Run generator: element store and the sequence of coloured pixel runs of a row.
`timescale 1ns / 1ps
module brr_runs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        take,
  input  logic                        wr_en,
  input  logic [brr_pkg::ELEM_AW-1:0] wr_addr,
  input  logic [7:0]                  wr_data,
  input  logic [7:0]                  n,
  input  logic [2:0]                  flags,
  input  logic [7:0]                  lpad,
  input  logic [7:0]                  rpad,
  input  logic [4:0]                  pm,
  input  logic [4:0]                  ueff,
  output brr_pkg::run_t               run
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LPAD = 9'b000000010,
    S_GA   = 9'b000000100,
    S_GB   = 9'b000001000,
    S_ELEM = 9'b000010000,
    S_TA   = 9'b000100000,
    S_TB   = 9'b001000000,
    S_TC   = 9'b010000000,
    S_RPAD = 9'b100000000
  } seq_t;

  typedef enum logic [2:0] {
    PH_FETCH = 3'b001,
    PH_MUL   = 3'b010,
    PH_SHOW  = 3'b100
  } ph_t;

  typedef enum logic [1:0] {
    ADJ_ZERO,
    ADJ_PLUS,
    ADJ_MINUS
  } adj_t;

  logic [7:0] store [brr_pkg::MAX_ELEMENTS];
  logic [7:0] rdata;
  logic [brr_pkg::ELEM_AW-1:0] rd_addr;

  seq_t st, st_next;
  ph_t  ph;
  logic [7:0] t;
  logic [brr_pkg::RUN_W-1:0] prod;
  logic [7:0] base;
  adj_t adj;
  logic colour;
  logic c;
  logic grd, rev;
  logic sub;
  logic [brr_pkg::RUN_W:0] sdiff;
  logic t_last;

  assign grd = flags[2];
  assign rev = flags[1];
  assign c   = ~flags[0] ^ (rev & ~n[0]);
  assign t_last = ((t + 8'd1) == n);
  assign rd_addr = rev ? brr_pkg::ELEM_AW'(n - 8'd1 - t) : t[brr_pkg::ELEM_AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    rdata <= store[rd_addr];
  end

  always_comb begin
    base   = 8'd1;
    adj    = ADJ_ZERO;
    colour = c;
    case (st)
      S_LPAD: begin base = lpad; colour = 1'b0; end
      S_GA:   adj = ADJ_PLUS;
      S_GB:   begin adj = ADJ_MINUS; colour = ~c; end
      S_ELEM: begin
        base   = rdata;
        colour = c ^ t[0];
        if (t[0]) begin
          adj = ADJ_MINUS;
        end else if (t_last && !grd) begin
          // trailing odd element without guards keeps its width
          adj = ADJ_ZERO;
        end else begin
          adj = ADJ_PLUS;
        end
      end
      S_TA:   adj = ADJ_PLUS;
      S_TB:   begin adj = ADJ_MINUS; colour = ~c; end
      S_TC:   adj = ADJ_ZERO;
      S_RPAD: begin base = rpad; colour = 1'b0; end
      default: base = 8'd0;
    endcase
  end

  // bars shrink and spaces grow: the sign of the shift follows the first colour
  assign sub = ((adj == ADJ_PLUS) && c) || ((adj == ADJ_MINUS) && !c);
  always_comb begin
    if (adj == ADJ_ZERO) begin
      sdiff = {1'b0, prod};
    end else if (sub) begin
      sdiff = {1'b0, prod} - {{(brr_pkg::RUN_W-4){1'b0}}, ueff};
    end else begin
      sdiff = {1'b0, prod} + {{(brr_pkg::RUN_W-4){1'b0}}, ueff};
    end
  end

  assign run.valid  = (ph == PH_SHOW) && (st != S_IDLE);
  assign run.width  = sdiff[brr_pkg::RUN_W] ? '0 : sdiff[brr_pkg::RUN_W-1:0];
  assign run.colour = colour;
  assign run.last   = (st == S_RPAD);

  always_comb begin
    st_next = st;
    case (st)
      S_LPAD: st_next = grd ? S_GA : ((n != 8'd0) ? S_ELEM : S_RPAD);
      S_GA:   st_next = S_GB;
      S_GB:   st_next = (n != 8'd0) ? S_ELEM : S_TA;
      S_ELEM: begin
        if (t_last) begin
          st_next = grd ? (n[0] ? S_TB : S_TA) : S_RPAD;
        end
      end
      S_TA:   st_next = S_TB;
      S_TB:   st_next = n[0] ? S_TC : S_RPAD;
      S_TC:   st_next = S_RPAD;
      S_RPAD: st_next = S_IDLE;
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      ph <= PH_FETCH;
      t  <= 8'd0;
    end else if (start) begin
      st <= S_LPAD;
      ph <= PH_FETCH;
      t  <= 8'd0;
    end else begin
      case (ph)
        PH_FETCH: if (st != S_IDLE) ph <= PH_MUL;
        PH_MUL:   ph <= PH_SHOW;
        PH_SHOW: begin
          if (take) begin
            ph <= PH_FETCH;
            st <= st_next;
            if (st == S_ELEM && !t_last) begin
              t <= t + 8'd1;
            end
          end
        end
        default: ph <= PH_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ph == PH_MUL) begin
      prod <= brr_pkg::RUN_W'(base * pm);
    end
  end

endmodule

// ===== rtl/brr_pack.sv =====
// Pixel packer: serialises runs into bytes and merges them with the previous row.
`timescale 1ns / 1ps
module brr_pack (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [6:0]            total,
  input  logic                  bmp,
  input  brr_pkg::run_t         run,
  output logic                  take,
  output brr_pkg::res_t         res
);

  typedef enum logic [6:0] {
    P_IDLE = 7'b0000001,
    P_LOAD = 7'b0000010,
    P_PIX  = 7'b0000100,
    P_RD   = 7'b0001000,
    P_OUT  = 7'b0010000,
    P_PAD  = 7'b0100000,
    P_DONE = 7'b1000000
  } pk_t;

  pk_t st;
  logic [brr_pkg::RUN_W-1:0] rem;
  logic colour;
  logic lastr;
  logic [7:0] sh;
  logic [3:0] nb;
  logic [6:0] k;
  logic [6:0] tot;
  logic [7:0] xm;
  logic [7:0] prev_mem [brr_pkg::LINE_BYTES];
  logic [brr_pkg::LINE_BYTES-1:0] prev_ok;
  logic [7:0] prev_q;
  logic prev_okq;
  logic [brr_pkg::LINE_AW-1:0] kidx;
  logic wr_en;
  logic [7:0] wr_data;
  logic fin;

  assign kidx = k[brr_pkg::LINE_AW-1:0];
  assign xm   = bmp ? brr_pkg::WHITE_BYTE : 8'h00;
  assign take = (st == P_LOAD) && run.valid;
  assign fin  = ((k + 7'd1) == tot);

  assign wr_en   = (st == P_OUT) || (st == P_PAD);
  assign wr_data = (st == P_OUT) ? sh : 8'h00;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prev_mem[kidx] <= wr_data;
    end
    prev_q <= prev_mem[kidx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_ok  <= '0;
      prev_okq <= 1'b0;
    end else begin
      prev_okq <= prev_ok[kidx];
      if (wr_en) begin
        prev_ok[kidx] <= 1'b1;
      end
    end
  end

  always_comb begin
    res.valid = 1'b0;
    res.line  = sh ^ xm;
    res.ucut  = (sh & (prev_okq ? prev_q : 8'h00)) ^ xm;
    res.last  = fin;
    case (st)
      P_OUT: res.valid = 1'b1;
      P_PAD: begin
        res.valid = 1'b1;
        res.line  = brr_pkg::WHITE_BYTE;
        res.ucut  = brr_pkg::WHITE_BYTE;
      end
      default: res.valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= P_IDLE;
    end else begin
      case (st)
        P_IDLE: if (start) st <= P_LOAD;
        P_LOAD: if (run.valid) st <= P_PIX;
        P_PIX: begin
          if (rem != '0 || (lastr && nb != 4'd0)) begin
            if (nb == 4'd7) st <= P_RD;
          end else if (!lastr) begin
            st <= P_LOAD;
          end else begin
            st <= P_PAD;
          end
        end
        P_RD:  st <= P_OUT;
        P_OUT: st <= fin ? P_DONE : P_PIX;
        P_PAD: st <= fin ? P_DONE : P_PAD;
        P_DONE: st <= P_IDLE;
        default: st <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      P_IDLE: begin
        k     <= 7'd0;
        nb    <= 4'd0;
        rem   <= '0;
        lastr <= 1'b0;
        tot   <= total;
      end
      P_LOAD: begin
        if (run.valid) begin
          rem    <= run.width;
          colour <= run.colour;
          lastr  <= run.last;
        end
      end
      P_PIX: begin
        if (rem != '0) begin
          sh  <= {sh[6:0], colour};
          nb  <= nb + 4'd1;
          rem <= rem - 1'b1;
        end else if (lastr && nb != 4'd0) begin
          // fill the final partial byte with white
          sh <= {sh[6:0], 1'b0};
          nb <= nb + 4'd1;
        end
      end
      P_OUT: begin
        k  <= k + 7'd1;
        nb <= 4'd0;
      end
      P_PAD: k <= k + 7'd1;
      default: k <= k;
    endcase
  end

endmodule

// ===== rtl/barcode_row_rasterizer.sv =====
// Barcode row rasterizer top level: configuration, row loading and pass control.
// The element item marked last starts rendering, during which busy stays high:
// a sizing pass walks the runs, then a second pass walks them again and shifts
// out one pixel per cycle, pausing to reload at each run and to emit each
// output byte, the white-filled last one included (previous-row read, then
// the result), and then emits any BMP pad bytes. Results come one per strobe
// and cannot be held off, so the receiver must take each in the cycle it
// appears. A row that overflows gives a single flagged result.
`timescale 1ns / 1ps
module barcode_row_rasterizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic        starts_white,
  input  logic        reversed,
  input  logic        with_guards,
  input  logic [7:0]  left_pad,
  input  logic [7:0]  right_pad,
  input  logic [7:0]  module_count,
  input  logic        last_element,
  output logic        valid,
  output logic [7:0]  line_byte,
  output logic [7:0]  undercut_byte,
  output logic        overflow,
  output logic        last_byte
);

  typedef enum logic [4:0] {
    T_IDLE  = 5'b00001,
    T_SIZE  = 5'b00010,
    T_CHECK = 5'b00100,
    T_OVF   = 5'b01000,
    T_EMIT  = 5'b10000
  } top_t;

  top_t st;
  logic [4:0] pix_mult;
  logic [4:0] x_undercut;
  logic       bmp_mode;
  logic [2:0] row_flags;
  logic [7:0] lpad, rpad;
  logic [7:0] element_count;
  logic [4:0] ueff;
  logic [9:0] acc;
  logic       ovf;
  logic [brr_pkg::RUN_W:0] sum;
  logic [10:0] acc7;
  logic [6:0] nbytes, total;
  logic [6:0] nb3;
  logic cfg_wr;
  logic accept;
  logic elem_wr;
  logic gen_start, pack_start;
  logic gen_take, pack_take;
  brr_pkg::run_t run;
  brr_pkg::res_t pres;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign busy   = (st != T_IDLE);
  assign accept = start && !busy;
  assign ueff   = (x_undercut < pix_mult) ? x_undercut : 5'd0;
  assign elem_wr = accept && (operation == brr_pkg::OP_ELEMENT) &&
                   (element_count < 8'(brr_pkg::MAX_ELEMENTS));

  always_comb begin
    case (paddr[3:2])
      brr_pkg::REG_PIX_MULT:   prdata = {27'd0, pix_mult};
      brr_pkg::REG_X_UNDERCUT: prdata = {27'd0, x_undercut};
      brr_pkg::REG_BMP_MODE:   prdata = {31'd0, bmp_mode};
      default:                 prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_mult   <= 5'd1;
      x_undercut <= 5'd0;
      bmp_mode   <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        brr_pkg::REG_PIX_MULT:   pix_mult   <= pwdata[4:0];
        brr_pkg::REG_X_UNDERCUT: x_undercut <= pwdata[4:0];
        brr_pkg::REG_BMP_MODE:   bmp_mode   <= pwdata[0];
        default:                 bmp_mode   <= bmp_mode;
      endcase
    end
  end

  assign sum    = {1'b0, run.width} + {{(brr_pkg::RUN_W-9){1'b0}}, acc};
  assign acc7   = {1'b0, acc} + 11'd7;
  assign nbytes = acc7[9:3];
  assign nb3    = nbytes + 7'd3;
  assign total  = bmp_mode ? {nb3[6:2], 2'b00} : nbytes;

  assign gen_start  = (st == T_IDLE && accept && operation == brr_pkg::OP_ELEMENT &&
                       last_element) || (st == T_CHECK && !ovf && total != 7'd0);
  assign pack_start = (st == T_CHECK) && !ovf && (total != 7'd0);
  assign gen_take   = (st == T_SIZE) ? run.valid : pack_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= T_IDLE;
      element_count <= 8'd0;
      row_flags     <= 3'd0;
      lpad          <= 8'd0;
      rpad          <= 8'd0;
      valid         <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (st)
        T_IDLE: begin
          if (accept) begin
            if (operation == brr_pkg::OP_HEADER) begin
              row_flags     <= {with_guards, reversed, starts_white};
              lpad          <= left_pad;
              rpad          <= right_pad;
              element_count <= 8'd0;
            end else begin
              if (elem_wr) element_count <= element_count + 8'd1;
              if (last_element) st <= T_SIZE;
            end
          end
        end
        T_SIZE: if (run.valid && run.last) st <= T_CHECK;
        T_CHECK: begin
          if (ovf) begin
            st <= T_OVF;
          end else if (total == 7'd0) begin
            st            <= T_IDLE;
            element_count <= 8'd0;
          end else begin
            st <= T_EMIT;
          end
        end
        T_OVF: begin
          valid         <= 1'b1;
          st            <= T_IDLE;
          element_count <= 8'd0;
        end
        T_EMIT: begin
          valid <= pres.valid;
          if (pres.valid && pres.last) begin
            st            <= T_IDLE;
            element_count <= 8'd0;
          end
        end
        default: st <= T_IDLE;
      endcase
    end
  end

  // sizing pass: add run widths and flag anything past the line
  always_ff @(posedge clk) begin
    if (gen_start && st == T_IDLE) begin
      acc <= 10'd0;
      ovf <= 1'b0;
    end else if (st == T_SIZE && run.valid) begin
      if (sum > (brr_pkg::RUN_W+1)'(brr_pkg::LINE_PIXELS)) begin
        ovf <= 1'b1;
      end else begin
        acc <= sum[9:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st == T_OVF) begin
      line_byte     <= 8'd0;
      undercut_byte <= 8'd0;
      overflow      <= 1'b1;
      last_byte     <= 1'b1;
    end else begin
      line_byte     <= pres.line;
      undercut_byte <= pres.ucut;
      overflow      <= 1'b0;
      last_byte     <= pres.last;
    end
  end

  brr_runs u_runs (
    .clk     (clk),
    .rst     (rst),
    .start   (gen_start),
    .take    (gen_take),
    .wr_en   (elem_wr),
    .wr_addr (element_count[brr_pkg::ELEM_AW-1:0]),
    .wr_data (module_count),
    .n       (element_count),
    .flags   (row_flags),
    .lpad    (lpad),
    .rpad    (rpad),
    .pm      (pix_mult),
    .ueff    (ueff),
    .run     (run)
  );

  brr_pack u_pack (
    .clk   (clk),
    .rst   (rst),
    .start (pack_start),
    .total (total),
    .bmp   (bmp_mode),
    .run   (run),
    .take  (pack_take),
    .res   (pres)
  );

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the barcode row rasterizer: row stimulus, line prediction, checks.
`timescale 1ns / 1ps
module testbench;

  typedef struct packed {
    logic       op;
    logic       sw;
    logic       rev;
    logic       grd;
    logic [7:0] lpad;
    logic [7:0] rpad;
    logic [7:0] mods;
    logic       last;
  } row_item_t;

  typedef struct packed {
    logic [7:0] line;
    logic [7:0] ucut;
    logic       ovf;
    logic       lastb;
  } line_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic        operation = 1'b0, starts_white = 1'b0, reversed = 1'b0, with_guards = 1'b0;
  logic [7:0]  left_pad = '0, right_pad = '0, module_count = '0;
  logic        last_element = 1'b0;
  logic        valid;
  logic [7:0]  line_byte, undercut_byte;
  logic        overflow, last_byte;

  barcode_row_rasterizer i_dut (.*);

  always #6 clk = ~clk;

  // predictor state
  logic [7:0]  elem_widths [brr_pkg::MAX_ELEMENTS];
  int unsigned elem_n;
  logic [2:0]  flags_q;
  logic [15:0] pads_q;
  logic [7:0]  prev_row [brr_pkg::LINE_BYTES];
  int          cfg_pm, cfg_xu, cfg_bmp;
  logic [7:0]  row_buf [brr_pkg::LINE_BYTES];
  int          px_pos;
  bit          px_full;

  row_item_t   pending_items[$];
  line_res_t   expected_bytes[$];
  int          errors, rows_rendered, overflows_seen, bytes_seen, items_sent;
  bit          gen_done;

  task automatic draw_run(input int w, input int colour);
    for (int n = 0; n < w; n++) begin
      if (px_full) return;
      if (px_pos >= brr_pkg::LINE_PIXELS) begin
        px_full = 1'b1;
        return;
      end
      if (colour & 1) row_buf[px_pos >> 3] |= 8'h80 >> (px_pos & 7);
      px_pos++;
    end
  endtask

  task automatic render_row();
    int pm, u, c, n, nbytes, total;
    bit rv, gd;
    int unsigned i;
    line_res_t r;
    pm = cfg_pm;
    u = (cfg_xu < cfg_pm) ? cfg_xu : 0;
    c = 0;
    n = elem_n;
    rv = flags_q[1];
    gd = flags_q[2];
    foreach (row_buf[k]) row_buf[k] = '0;
    px_pos = 0;
    px_full = 1'b0;
    if (!flags_q[0]) begin
      c = 1;
      u = -u;
    end
    if (rv && (n % 2) == 0) begin
      c ^= 1;
      u = -u;
    end
    draw_run(pads_q[7:0] * pm, 0);
    if (gd) begin
      draw_run(pm + u, c);
      draw_run(pm - u, c ^ 1);
    end
    for (i = 0; i + 1 < n; i += 2) begin
      draw_run(elem_widths[rv ? n - 1 - i : i] * pm + u, c);
      draw_run(elem_widths[rv ? n - 2 - i : i + 1] * pm - u, c ^ 1);
    end
    if (i < n) begin
      if (gd) begin
        draw_run(elem_widths[rv ? 0 : i] * pm + u, c);
        draw_run(pm - u, c ^ 1);
        draw_run(pm, c);
      end else begin
        draw_run(elem_widths[rv ? 0 : i] * pm, c);
      end
    end else if (gd) begin
      draw_run(pm + u, c);
      draw_run(pm - u, c ^ 1);
    end
    draw_run(pads_q[15:8] * pm, 0);
    nbytes = (px_pos + 7) / 8;
    total = cfg_bmp ? ((nbytes + 3) & ~3) : nbytes;
    if (px_full || total > brr_pkg::LINE_BYTES) begin
      expected_bytes.push_back('{8'h00, 8'h00, 1'b1, 1'b1});
      return;
    end
    for (int k = 0; k < total; k++) begin
      if (k < nbytes) begin
        r.line = row_buf[k] ^ (cfg_bmp ? 8'hFF : 8'h00);
        r.ucut = (row_buf[k] & prev_row[k]) ^ (cfg_bmp ? 8'hFF : 8'h00);
        prev_row[k] = row_buf[k];
      end else begin
        r.line = brr_pkg::WHITE_BYTE;
        r.ucut = brr_pkg::WHITE_BYTE;
        prev_row[k] = '0;
      end
      r.ovf = 1'b0;
      r.lastb = (k + 1 == total);
      expected_bytes.push_back(r);
    end
  endtask

  task automatic predict_item(input row_item_t it);
    if (it.op == brr_pkg::OP_HEADER) begin
      flags_q = {it.grd, it.rev, it.sw};
      pads_q = {it.rpad, it.lpad};
      elem_n = 0;
      return;
    end
    if (elem_n < brr_pkg::MAX_ELEMENTS) begin
      elem_widths[elem_n] = it.mods;
      elem_n++;
    end
    if (it.last) begin
      render_row();
      elem_n = 0;
    end
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // busy as seen at the last rising edge
  logic busy_s = 1'b0;
  always @(posedge clk) busy_s <= busy;

  // driver: presents items at the falling edge, holds until accepted
  int gap_cnt = 0;
  row_item_t cur;
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !busy_s) begin
        predict_item(cur);
        items_sent++;
      end
      if (start && busy_s) begin
        // hold
      end else if (gap_cnt > 0) begin
        gap_cnt--;
        start <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cur = pending_items.pop_front();
        {operation, starts_white, reversed, with_guards} <= {cur.op, cur.sw, cur.rev, cur.grd};
        {left_pad, right_pad, module_count, last_element} <=
          {cur.lpad, cur.rpad, cur.mods, cur.last};
        start <= 1'b1;
        gap_cnt = gap_len();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    line_res_t e;
    if (!rst && valid) begin
      bytes_seen++;
      if (overflow) overflows_seen++;
      if (last_byte) rows_rendered++;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte line=%h ucut=%h ovf=%b last=%b", $time,
                 line_byte, undercut_byte, overflow, last_byte);
      end else begin
        e = expected_bytes.pop_front();
        if (e.line !== line_byte) begin
          errors++;
          $display("%0t: line_byte expected %h actual %h", $time, e.line, line_byte);
        end
        if (e.ucut !== undercut_byte) begin
          errors++;
          $display("%0t: undercut_byte expected %h actual %h", $time, e.ucut, undercut_byte);
        end
        if (e.ovf !== overflow) begin
          errors++;
          $display("%0t: overflow expected %b actual %b", $time, e.ovf, overflow);
        end
        if (e.lastb !== last_byte) begin
          errors++;
          $display("%0t: last_byte expected %b actual %b", $time, e.lastb, last_byte);
        end
      end
    end
  end

  task automatic push_header(input bit sw, rv, gd, input int lp, rp);
    pending_items.push_back('{brr_pkg::OP_HEADER, sw, rv, gd, lp[7:0], rp[7:0],
                              8'($urandom), 1'($urandom)});
  endtask

  task automatic push_elem(input int m, input bit lst);
    pending_items.push_back('{brr_pkg::OP_ELEMENT, 1'($urandom), 1'($urandom), 1'($urandom),
                              8'($urandom), 8'($urandom), m[7:0], lst});
  endtask

  task automatic push_row(input int n, input int maxw, input int maxpad);
    push_header(1'($urandom), 1'($urandom), 1'($urandom), $urandom_range(0, maxpad),
                $urandom_range(0, maxpad));
    for (int k = 0; k < n; k++) push_elem($urandom_range(0, maxw), k == n - 1);
  endtask

  task automatic reg_write(input logic [1:0] idx, input int val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == brr_pkg::REG_PIX_MULT) cfg_pm = val & 31;
    else if (idx == brr_pkg::REG_X_UNDERCUT) cfg_xu = val & 31;
    else cfg_bmp = val & 1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // let the queue drain and the block settle before touching registers
  task automatic run_phase();
    while (pending_items.size() > 0 || start || busy_s || expected_bytes.size() > 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
    while (busy_s || expected_bytes.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_cfg(input int pm, xu, bmp);
    reg_write(brr_pkg::REG_PIX_MULT, pm);
    reg_write(brr_pkg::REG_X_UNDERCUT, xu);
    reg_write(brr_pkg::REG_BMP_MODE, bmp);
  endtask

  initial begin
    int cfgs[6][3];
    cfgs = '{'{1, 0, 0}, '{31, 30, 1}, '{3, 1, 0}, '{2, 5, 1}, '{4, 3, 1}, '{1, 0, 1}};
    foreach (prev_row[k]) prev_row[k] = '0;
    elem_n = 0; flags_q = '0; pads_q = '0;
    cfg_pm = 1; cfg_xu = 0; cfg_bmp = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    // directed: element with no header, extremes, guards, reverse, empty row
    push_elem(255, 1'b0); push_elem(0, 1'b1);
    push_header(0, 0, 0, 0, 0); push_elem(0, 1'b1);
    push_header(1, 1, 1, 2, 3); push_elem(3, 1'b0); push_elem(2, 1'b0); push_elem(1, 1'b1);
    push_header(0, 1, 1, 0, 0); push_elem(1, 1'b0); push_elem(4, 1'b1);
    push_header(1, 0, 0, 255, 255); push_elem(1, 1'b1);
    push_header(0, 0, 1, 1, 1); push_elem(2, 1'b1);
    run_phase();
    // too many elements: last mark beyond the store still renders
    push_header(0, 0, 0, 0, 0);
    for (int k = 0; k < brr_pkg::MAX_ELEMENTS + 3; k++)
      push_elem($urandom_range(0, 3), k == brr_pkg::MAX_ELEMENTS + 2);
    run_phase();
    for (int c = 0; c < 6; c++) begin
      set_cfg(cfgs[c][0], cfgs[c][1], cfgs[c][2]);
      if (c == 1) begin
        push_header(1, 1, 1, 0, 0); push_elem(1, 1'b0); push_elem(1, 1'b1);
      end
      for (int r = 0; r < 4; r++) begin
        if ($urandom_range(0, 9) == 0)
          push_elem($urandom, 1'($urandom_range(0, 1)));   // stray element
        push_row($urandom_range(1, 7), (cfgs[c][0] > 4) ? 3 : 12,
                 ($urandom_range(0, 5) == 0) ? 255 : 6);
      end
      run_phase();
    end
    run_phase();
    $display("Rows rendered: %0d (%0d overflowed), bytes checked: %0d, items sent: %0d",
             rows_rendered, overflows_seen, bytes_seen, items_sent);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
